// ----- hdl/txrb_pkg.sv -----
// Shared types and constants of the transmit ring buffer chunk dispatcher.
// No dependencies.
`default_nettype none

package txrb_pkg;

    localparam int DEPTH_DEF = 4096;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int RIDX_W   = 12;
    localparam int CHUNK_W  = 12;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 32;

    // input transaction kinds
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    typedef enum logic [1:0] {
        ST_CHUNK = 2'd0,
        ST_IDLE  = 2'd1,
        ST_DROP  = 2'd2,
        ST_READ  = 2'd3
    } status_t;

    // result from the pointer control to the output stage
    typedef struct packed {
        logic                vld;
        status_t             status;
        logic [CHUNK_W-1:0]  start;
        logic [CHUNK_W-1:0]  len;
    } txrb_res_t;

endpackage

`default_nettype wire

// ----- hdl/tx_ring_buffer_chunk_dispatcher.sv -----
// Top level of the transmit ring buffer chunk dispatcher: byte store, read path, output register.
// Depends on txrb_pkg and txrb_ctrl.
`default_nettype none

// Usage
//   Slave channel (s_*): one transaction per message byte, transfer completion
//   or buffer read, selected by the kind in s_tuser. Message bytes carry first
//   in s_tuser and last in s_tlast; msg_len counts on the first byte only.
//   Master channel (m_*): status in m_tuser, chunk descriptor or read byte in
//   m_tdata. Bytes, completions and unused kinds give zero or one result.
// Results: chunk, idle and drop results are in the output register in the
//   cycle after the input transaction. Read results pass first through the
//   byte store's registered read port, then through the output register.
// Throughput: one transaction per cycle for message bytes and completions
//   while the output register is free or taken; a read holds the input while
//   the store read completes, until its data has moved to the output register.
// Reset: head, committed tail, write pointer, busy and drop state clear; the
//   byte store keeps whatever it holds, a never-written slot reads undefined.
//   No clearing pass is run, so input is taken right after reset.
// Stall: a single output register parts the channels. While it holds an
//   untaken result, s_tready drops; the block takes a new transaction in the
//   same cycle the receiver takes the pending result.
module tx_ring_buffer_chunk_dispatcher
    import txrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // data_byte[7:0], msg_len[23:8], read_index[35:24], zero[39:36]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // kind[1:0], first[2]
    input  wire logic [S_USER_W-1:0]  s_tuser,
    input  wire logic                 s_tlast,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // chunk_start[11:0], chunk_len[23:12], read_data[31:24]
    output logic [M_DATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [KIND_W-1:0]         m_tuser
);

    localparam int PW = $clog2(DEPTH);

    logic [BYTE_W-1:0]   mem [DEPTH];

    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    msg_len;
    logic [RIDX_W-1:0]   read_index;
    logic                first;
    logic                acc;

    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    txrb_res_t           res;

    logic [31:0]         ridx_w;
    logic [PW-1:0]       rd_addr;
    logic                rd_en;

    logic                rd_pend_reg, rd_pend_next;
    logic                rd_oor_reg;
    logic [BYTE_W-1:0]   rdata_reg;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [CHUNK_W-1:0]  out_start_reg, out_start_next;
    logic [CHUNK_W-1:0]  out_len_reg, out_len_next;
    logic [BYTE_W-1:0]   out_data_reg, out_data_next;

    assign kind       = s_tuser[KIND_W-1:0];
    assign first      = s_tuser[KIND_W];
    assign data_byte  = s_tdata[BYTE_W-1:0];
    assign msg_len    = s_tdata[BYTE_W+LEN_W-1:BYTE_W];
    assign read_index = s_tdata[BYTE_W+LEN_W+RIDX_W-1:BYTE_W+LEN_W];

    // hold input while a store read is in progress or the result is untaken
    assign s_tready = !rd_pend_reg && (!out_valid_reg || m_tready);
    assign acc      = s_tvalid && s_tready;

    assign ridx_w  = 32'(read_index);
    assign rd_addr = ridx_w[PW-1:0];
    assign rd_en   = acc && (kind == KIND_READ);

    txrb_ctrl #(
        .DEPTH   (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .kind    (kind),
        .first   (first),
        .last    (s_tlast),
        .msg_len (msg_len),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .res     (res)
    );

    // byte store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= data_byte;
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_addr];
            rd_oor_reg <= ridx_w >= 32'(DEPTH);
        end
    end

    always_comb
    begin
        rd_pend_next    = rd_en;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_data_next   = out_data_reg;

        if (rd_pend_reg)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_READ;
            out_start_next  = '0;
            out_len_next    = '0;
            out_data_next   = rd_oor_reg ? '0 : rdata_reg;
        end
        else if (res.vld)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res.status;
            out_start_next  = res.start;
            out_len_next    = res.len;
            out_data_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_len_reg    <= out_len_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_data_reg, out_len_reg, out_start_reg};

endmodule

`default_nettype wire

// ----- hdl/txrb_ctrl.sv -----
// Pointer control: head, committed tail, write pointer, admission and chunk dispatch.
// Depends on txrb_pkg.
`default_nettype none

module txrb_ctrl
    import txrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        acc,
    input  wire logic [KIND_W-1:0]           kind,
    input  wire logic                        first,
    input  wire logic                        last,
    input  wire logic [LEN_W-1:0]            msg_len,
    output logic                             wr_en,
    output logic [$clog2(DEPTH)-1:0]         wr_addr,
    output txrb_res_t                        res
);

    localparam int PW = $clog2(DEPTH);
    localparam int W1 = PW + 1;
    localparam logic [W1-1:0] DEPTH_W1 = W1'(DEPTH);
    localparam logic [PW-1:0] MAX_FREE = PW'(DEPTH - 1);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] wi_reg, wi_next;
    logic [PW-1:0] infl_reg, infl_next;
    logic          busy_reg, busy_next;
    logic          drop_reg, drop_next;

    logic [PW-1:0] free_sp;
    logic          len_big;
    logic [PW-1:0] wi_eff, wi_inc, wi_new;
    logic          do_disp;
    logic [PW-1:0] d_head, d_tail;
    logic [PW-1:0] pending, chunk;
    logic [W1-1:0] room;
    logic [31:0]   start_w, len_w;

    // (a + b) mod DEPTH for a, b below DEPTH
    function automatic logic [PW-1:0] ring_add(logic [PW-1:0] a, logic [PW-1:0] b);
        logic [W1-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W1)
            s = s - DEPTH_W1;
        return s[PW-1:0];
    endfunction

    // (t - h) mod DEPTH
    function automatic logic [PW-1:0] ring_dist(logic [PW-1:0] t, logic [PW-1:0] h);
        logic [W1-1:0] d;
        d = {1'b0, t} - {1'b0, h};
        if (t < h)
            d = d + DEPTH_W1;
        return d[PW-1:0];
    endfunction

    assign free_sp = MAX_FREE - ring_dist(tail_reg, head_reg);
    assign len_big = 32'(msg_len) > 32'(free_sp);
    assign wi_eff  = first ? tail_reg : wi_reg;
    assign wi_inc  = ring_add(wi_eff, PW'(1));

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        wi_next   = wi_reg;
        infl_next = infl_reg;
        busy_next = busy_reg;
        drop_next = drop_reg;
        wr_en     = 1'b0;
        wr_addr   = wi_eff;
        wi_new    = wi_eff;
        do_disp   = 1'b0;
        d_head    = head_reg;
        d_tail    = tail_reg;
        res       = '0;

        if (acc)
        begin
            case (kind)
                KIND_BYTE:
                begin
                    if (first && len_big)
                    begin
                        wi_next    = tail_reg;
                        drop_next  = !last;
                        res.vld    = 1'b1;
                        res.status = ST_DROP;
                    end
                    else if (!first && drop_reg)
                    begin
                        if (last)
                            drop_next = 1'b0;
                    end
                    else
                    begin
                        drop_next = 1'b0;
                        // the slot before head stays free
                        if (wi_inc != head_reg)
                        begin
                            wr_en  = 1'b1;
                            wi_new = wi_inc;
                        end
                        wi_next = wi_new;
                        if (last)
                        begin
                            tail_next = wi_new;
                            d_tail    = wi_new;
                            do_disp   = !busy_reg;
                        end
                    end
                end
                KIND_DONE:
                begin
                    if (busy_reg)
                    begin
                        head_next = ring_add(head_reg, infl_reg);
                        d_head    = head_next;
                        do_disp   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        pending = ring_dist(d_tail, d_head);
        room    = DEPTH_W1 - {1'b0, d_head};
        chunk   = ({1'b0, pending} < room) ? pending : room[PW-1:0];
        start_w = 32'(d_head);
        len_w   = 32'(chunk);

        if (do_disp)
        begin
            res.vld = 1'b1;
            if (pending == '0)
            begin
                busy_next  = 1'b0;
                infl_next  = '0;
                res.status = ST_IDLE;
            end
            else
            begin
                busy_next  = 1'b1;
                infl_next  = chunk;
                res.status = ST_CHUNK;
                res.start  = start_w[CHUNK_W-1:0];
                res.len    = len_w[CHUNK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            wi_reg   <= '0;
            infl_reg <= '0;
            busy_reg <= 1'b0;
            drop_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            wi_reg   <= wi_next;
            infl_reg <= infl_next;
            busy_reg <= busy_next;
            drop_reg <= drop_next;
        end
    end

endmodule

`default_nettype wire
